FILE: rtl/sts_pkg.sv
package sts_pkg;

  localparam int CAPACITY   = 64;
  localparam int MAX_FIELDS = 3;
  localparam int FIELD_W    = 64;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [1:0] ARITY_RESET = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a;
    logic signed [FIELD_W-1:0] b;
    logic signed [FIELD_W-1:0] c;
  } tuple_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_key;
    logic              load_key;
    logic              cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic             lt;
    logic             eq;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

FILE: rtl/sorted_tuple_set_core.sv
// Sorted set of up to 64 tuples of one to three signed 64-bit fields.
// Input channel: in_valid_i / in_stall_o with func_i (0 insert, 1 query)
// and field_a_i..field_c_i. Output channel: out_valid_o / out_stall_i with
// status_o and entry_count_o; every item gives exactly one result.
// cfg_we_i writes cfg_wdata_i to the tuple arity (0 acts as 1); write it
// only while no item is in flight.
// One item is worked at a time on an entry memory with one read port and
// one write port. An insert runs a binary search of at most 7 probes,
// each a read and then a compare, moves each entry at or above the slot
// up by one, and then stores the tuple. A query scans the held entries
// at one per cycle and stops at the first match.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, a finished result holds the block
// until the output register is free. Reset empties the set and sets the
// arity to three; the memory needs no clearing.
module sorted_tuple_set_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [63:0] field_a_i,
  input  logic [63:0] field_b_i,
  input  logic [63:0] field_c_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [6:0]  entry_count_o
);
  import sts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  sts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .field_a_i   (field_a_i),
    .field_b_i   (field_b_i),
    .field_c_i   (field_c_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> entry_count_o <= 7'(CAPACITY))
    else $error("entry count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && status_o == ST_FULL |-> entry_count_o == 7'(CAPACITY))
    else $error("full reject below capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

endmodule

FILE: rtl/sts_datapath.sv
module sts_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_wdata_i,
  input  logic [sts_pkg::FIELD_W-1:0]  field_a_i,
  input  logic [sts_pkg::FIELD_W-1:0]  field_b_i,
  input  logic [sts_pkg::FIELD_W-1:0]  field_c_i,
  input  sts_pkg::cmd_t                cmd_i,
  output sts_pkg::stat_t               stat_o
);
  import sts_pkg::*;

  tuple_t           mem [CAPACITY];
  tuple_t           rd_q;
  tuple_t           key_q;
  tuple_t           wr_data;
  logic [1:0]       arity_q;
  logic [1:0]       arity_eff;
  logic [CNT_W-1:0] count_q;
  logic             eq_a, eq_b, eq_c;
  logic             lt_a, lt_b, lt_c;
  logic             use_b, use_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arity_q <= ARITY_RESET;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        arity_q <= cfg_wdata_i;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= '{a: field_a_i, b: field_b_i, c: field_c_i};
    end
  end

  assign wr_data = cmd_i.wr_key ? key_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_addr];
    end
  end

  always_comb begin
    arity_eff = arity_q;
    if (arity_eff == 2'd0) begin
      arity_eff = 2'd1;
    end
    if (32'(arity_eff) > MAX_FIELDS) begin
      arity_eff = 2'(MAX_FIELDS);
    end
  end

  assign use_b = arity_eff >= 2'd2;
  assign use_c = arity_eff >= 2'd3;
  assign eq_a  = rd_q.a == key_q.a;
  assign eq_b  = rd_q.b == key_q.b;
  assign eq_c  = rd_q.c == key_q.c;
  assign lt_a  = $signed(rd_q.a) < $signed(key_q.a);
  assign lt_b  = $signed(rd_q.b) < $signed(key_q.b);
  assign lt_c  = $signed(rd_q.c) < $signed(key_q.c);

  assign stat_o.eq    = eq_a && (!use_b || eq_b) && (!use_c || eq_c);
  assign stat_o.lt    = lt_a || (eq_a && use_b && (lt_b || (eq_b && use_c && lt_c)));
  assign stat_o.count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
    end else begin
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.cnt_inc |-> count_q < CNT_W'(CAPACITY))
    else $error("insert into a full store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.wr_en && cmd_i.rd_en |-> cmd_i.wr_addr != cmd_i.rd_addr)
    else $error("read and write at the same entry");

endmodule

FILE: rtl/sts_ctrl.sv
module sts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           func_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     status_o,
  output logic [6:0]     entry_count_o,
  output sts_pkg::cmd_t  cmd_o,
  input  sts_pkg::stat_t stat_i
);
  import sts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PROBE,
    S_SHIFT,
    S_INS_WR,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  lo_q, hi_q, mid_q, idx_q;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid_c;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] ptr_q;
  logic              pend_q;
  logic [2:0]        res_q;
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [6:0]        out_count_q;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c   = mid_sum[CNT_W:1];
  assign cnt_m1  = stat_i.count - CNT_W'(1);

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_key = in_valid_i;
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = mid_c[ADDR_W-1:0];
        end else if (stat_i.count < CNT_W'(CAPACITY) && stat_i.count > lo_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = cnt_m1[ADDR_W-1:0];
        end
      end
      S_SHIFT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = ptr_q + ADDR_W'(1);
        if ({1'b0, ptr_q} > lo_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ptr_q - ADDR_W'(1);
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = lo_q[ADDR_W-1:0];
        cmd_o.wr_key  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_SCAN: begin
        if (!(pend_q && stat_i.eq) && idx_q < stat_i.count) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_q[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      idx_q        <= '0;
      ptr_q        <= '0;
      pend_q       <= 1'b0;
      res_q        <= ST_INSERTED;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_INSERTED;
      out_count_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_RESULT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            lo_q    <= '0;
            hi_q    <= stat_i.count;
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= (func_i == FUNC_QUERY) ? S_SCAN : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid_c;
            state_q <= S_PROBE;
          end else if (stat_i.count >= CNT_W'(CAPACITY)) begin
            res_q   <= ST_FULL;
            state_q <= S_RESULT;
          end else if (stat_i.count > lo_q) begin
            ptr_q   <= cnt_m1[ADDR_W-1:0];
            state_q <= S_SHIFT;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_PROBE: begin
          if (stat_i.eq) begin
            res_q   <= ST_DUPLICATE;
            state_q <= S_RESULT;
          end else begin
            if (stat_i.lt) begin
              lo_q <= mid_q + CNT_W'(1);
            end else begin
              hi_q <= mid_q;
            end
            state_q <= S_SEARCH;
          end
        end
        S_SHIFT: begin
          if ({1'b0, ptr_q} > lo_q) begin
            ptr_q <= ptr_q - ADDR_W'(1);
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          res_q   <= ST_INSERTED;
          state_q <= S_RESULT;
        end
        S_SCAN: begin
          if (pend_q && stat_i.eq) begin
            res_q   <= ST_FOUND;
            state_q <= S_RESULT;
          end else if (idx_q < stat_i.count) begin
            idx_q  <= idx_q + CNT_W'(1);
            pend_q <= 1'b1;
          end else begin
            res_q   <= ST_NOT_FOUND;
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_q;
            out_count_q  <= 7'(stat_i.count);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_SHIFT |-> stat_i.count < CNT_W'(CAPACITY))
    else $error("shift with a full store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_PROBE |-> mid_q < stat_i.count)
    else $error("probe beyond held entries");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_SEARCH |-> lo_q <= hi_q && hi_q <= stat_i.count)
    else $error("search bounds out of order");

endmodule
